// File: design/area_weighted_mip_downsample_assert.svh
// assertion macros for the mip downsampler
// no dependencies; expects clk and rst_n in the including scope
`ifndef AREA_WEIGHTED_MIP_DOWNSAMPLE_ASSERT_SVH
`define AREA_WEIGHTED_MIP_DOWNSAMPLE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define AWMD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define AWMD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AWMD_ASSERT_NOW(label, ante, cons)
`define AWMD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: design/awmd_pkg.sv
// shared types, constants and helpers of the mip downsampler
// no dependencies
`default_nettype none
package awmd_pkg;
    localparam int SIZE_W    = 13;
    localparam int POS_W     = 12;
    localparam int TGT_W     = 11;
    localparam int WGT_W     = 12;
    localparam int PROD_W    = 24;
    localparam int ACC_W     = 40;
    localparam int ACC_AW    = 12;
    localparam int ACC_DEPTH = 4096;
    localparam int AREA_W    = 25;
    localparam int CH_W      = 16;
    localparam int NCH       = 4;
    localparam int QUO_BITS  = 16;
    localparam int CNT_W     = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [SIZE_W-1:0]    MAX_SIZE        = 13'd4096;
    localparam logic [CFG_IDX_W-1:0] REG_PREV_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PREV_HEIGHT = 1'd1;

    typedef struct packed {
        logic [CH_W-1:0] src_red;
        logic [CH_W-1:0] src_green;
        logic [CH_W-1:0] src_blue;
        logic [CH_W-1:0] src_alpha;
    } src_t;

    typedef struct packed {
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
        logic [CH_W-1:0] out_alpha;
        logic            level_done;
    } res_t;

    typedef struct packed {
        logic [TGT_W-1:0] t;
        logic [WGT_W-1:0] w0;
        logic [WGT_W-1:0] w1;
        logic             two;
        logic             first0;
        logic             last0;
        logic             at_end;
    } axis_info_t;

    typedef logic [NCH-1:0][ACC_W-1:0] acc_word_t;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v == '0)
            r = SIZE_W'(1);
        else if (v > MAX_SIZE)
            r = MAX_SIZE;
        return r;
    endfunction

    function automatic logic [WGT_W-1:0] half_size(input logic [SIZE_W-1:0] p);
        logic [WGT_W-1:0] r;
        r = p[SIZE_W-1:1];
        if (r == '0)
            r = WGT_W'(1);
        return r;
    endfunction
endpackage
`default_nettype wire

// File: design/awmd_acc_ram.sv
// accumulator memory, one write and one registered read port
// depends on awmd_pkg
`default_nettype none
module awmd_acc_ram
    import awmd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ACC_AW-1:0] waddr,
    input  wire acc_word_t         wdata,
    input  wire logic              re,
    input  wire logic [ACC_AW-1:0] raddr,
    output acc_word_t              rdata
);
    acc_word_t mem [ACC_DEPTH];
    acc_word_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// File: design/awmd_axis.sv
// position tracker of one axis: source index, offset into target, target index
// depends on awmd_pkg
`default_nettype none
module awmd_axis
    import awmd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [SIZE_W-1:0] size,
    input  wire logic [WGT_W-1:0]  half,
    input  wire logic              restart,
    input  wire logic              step,
    output axis_info_t             info
);
    logic [POS_W-1:0]  idx_reg, idx_next;
    logic [POS_W-1:0]  ofs_reg, ofs_next;
    logic [TGT_W-1:0]  tgt_reg, tgt_next;
    logic [SIZE_W-1:0] span_end;
    logic [SIZE_W-1:0] size_m1;
    logic [SIZE_W-1:0] front;
    logic [SIZE_W-1:0] spill;
    logic              wrap;

    always_comb
    begin
        span_end = {1'b0, ofs_reg} + {1'b0, half};
        size_m1  = size - SIZE_W'(1);
        front    = size - {1'b0, ofs_reg};
        spill    = span_end - size;
        wrap     = span_end >= size;

        info.t      = tgt_reg;
        info.two    = span_end > size;
        info.w0     = info.two ? front[WGT_W-1:0] : half;
        info.w1     = spill[WGT_W-1:0];
        info.first0 = ofs_reg == '0;
        info.last0  = wrap;
        info.at_end = {1'b0, idx_reg} == size_m1;

        idx_next = idx_reg;
        ofs_next = ofs_reg;
        tgt_next = tgt_reg;
        if (restart || (step && info.at_end))
        begin
            idx_next = '0;
            ofs_next = '0;
            tgt_next = '0;
        end
        else if (step)
        begin
            idx_next = idx_reg + POS_W'(1);
            ofs_next = wrap ? spill[POS_W-1:0] : span_end[POS_W-1:0];
            tgt_next = tgt_reg + TGT_W'(wrap);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            ofs_reg <= '0;
            tgt_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            ofs_reg <= ofs_next;
            tgt_reg <= tgt_next;
        end
    end
endmodule
`default_nettype wire

// File: design/awmd_div.sv
// rounding divider, one quotient bit per cycle, saturates at full scale
// depends on awmd_pkg
`default_nettype none
module awmd_div
    import awmd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [ACC_W-1:0]  sum,
    input  wire logic [AREA_W-1:0] den,
    output logic                   done,
    output logic [CH_W-1:0]        quot
);
    logic [AREA_W-1:0]   rem_reg, rem_next;
    logic [QUO_BITS-1:0] quo_reg, quo_next;
    logic                ovf_reg, ovf_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [ACC_W:0]      num;
    logic [AREA_W:0]     trial;
    logic [AREA_W:0]     diff;
    logic                ge;

    always_comb
    begin
        num   = {1'b0, sum} + {17'b0, den[AREA_W-1:1]};
        trial = {rem_reg, quo_reg[QUO_BITS-1]};
        ge    = trial >= {1'b0, den};
        diff  = trial - {1'b0, den};

        rem_next  = rem_reg;
        quo_next  = quo_reg;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        done_next = (cnt_reg == CNT_W'(1));
        if (start)
        begin
            rem_next = num[ACC_W:QUO_BITS];
            quo_next = num[QUO_BITS-1:0];
            ovf_next = num[ACC_W:QUO_BITS] >= den;
            cnt_next = CNT_W'(QUO_BITS);
        end
        else if (cnt_reg != '0)
        begin
            rem_next = ge ? diff[AREA_W-1:0] : trial[AREA_W-1:0];
            quo_next = {quo_reg[QUO_BITS-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        ovf_reg <= ovf_next;
    end

    assign done = done_reg;
    assign quot = ovf_reg ? {CH_W{1'b1}} : quo_reg;
endmodule
`default_nettype wire

// File: design/area_weighted_mip_downsample.sv
// top level of the area-weighted mip downsampler
// depends on awmd_pkg, awmd_axis, awmd_acc_ram, awmd_div and the assertion header
//
//  channel | signals                          | beat
//  --------+----------------------------------+-------------------------------
//  in      | in_valid, in_stall, in_data      | one source texel, raster order
//  out     | out_valid, out_stall, out_data   | one target texel + level_done
//  cfg     | cfg_write, cfg_index, cfg_data   | prev_width (0), prev_height (1)
//
// per texel, up to four accumulator entries are read,
// weighted and written back in turn through the single accumulator memory
// a texel that completes a target texel also runs the 16-step divider
// a finished texel sits in the output register, so a stalled output only
// holds the block once a second result is ready; reset needs no clearing pass
`default_nettype none
`include "area_weighted_mip_downsample_assert.svh"
module area_weighted_mip_downsample
    import awmd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire src_t                 in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output res_t                      out_data,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [SIZE_W-1:0]    cfg_data
);
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RD     = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_WR     = 3'd3;
    localparam logic [2:0] S_DSTART = 3'd4;
    localparam logic [2:0] S_DIV    = 3'd5;
    localparam logic [2:0] S_PUT    = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [1:0]        upd_reg, upd_next;
    logic [SIZE_W-1:0] pw_reg, pw_next;
    logic [SIZE_W-1:0] ph_reg, ph_next;
    logic              have_last_reg, have_last_next;
    logic              out_valid_reg, out_valid_next;
    res_t              out_data_reg, out_data_next;

    logic [AREA_W-1:0] area_reg;
    src_t              val_reg;
    axis_info_t        xi_reg, yi_reg;
    logic [ACC_AW-1:0] addr_reg;
    logic              first_reg, last_reg;
    logic              level_reg;
    logic [PROD_W-1:0] wprod_reg;
    acc_word_t         term_reg;
    acc_word_t         sum_reg;

    logic [SIZE_W-1:0] pw_c, ph_c;
    logic [WGT_W-1:0]  hw_c, hh_c;
    axis_info_t        xi, yi;
    logic              in_accept;
    logic              dx, dy;
    logic              upd_ok;
    logic [WGT_W-1:0]  wx, wy;
    logic [TGT_W-1:0]  tx, ty;
    logic              first_u, last_u, level_u;
    logic [WGT_W-1:0]  hw_m1, hh_m1;
    logic [NCH-1:0][CH_W-1:0] chan_val;
    acc_word_t         rdata;
    acc_word_t         sum;
    logic [NCH-1:0]    div_done;
    logic [NCH-1:0][CH_W-1:0] quot;
    logic              upd_last;
    logic              out_load;

    assign pw_c = clamp_size(pw_reg);
    assign ph_c = clamp_size(ph_reg);
    assign hw_c = half_size(pw_c);
    assign hh_c = half_size(ph_c);

    assign in_stall  = state_reg != S_IDLE;
    assign in_accept = in_valid && !in_stall;

    awmd_axis u_axis_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .size    (pw_c),
        .half    (hw_c),
        .restart (cfg_write),
        .step    (in_accept),
        .info    (xi)
    );

    awmd_axis u_axis_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .size    (ph_c),
        .half    (hh_c),
        .restart (cfg_write),
        .step    (in_accept && xi.at_end),
        .info    (yi)
    );

    assign chan_val = {val_reg.src_red, val_reg.src_green, val_reg.src_blue,
                       val_reg.src_alpha};

    always_comb
    begin
        dx      = upd_reg[0];
        dy      = upd_reg[1];
        upd_ok  = (!dx || xi_reg.two) && (!dy || yi_reg.two);
        wx      = dx ? xi_reg.w1 : xi_reg.w0;
        wy      = dy ? yi_reg.w1 : yi_reg.w0;
        tx      = xi_reg.t + TGT_W'(dx);
        ty      = yi_reg.t + TGT_W'(dy);
        first_u = (dx || xi_reg.first0) && (dy || yi_reg.first0);
        last_u  = !dx && !dy && xi_reg.last0 && yi_reg.last0;
        hw_m1   = hw_c - WGT_W'(1);
        hh_m1   = hh_c - WGT_W'(1);
        level_u = ({1'b0, xi_reg.t} == hw_m1) && ({1'b0, yi_reg.t} == hh_m1);
    end

    awmd_acc_ram u_ram (
        .clk   (clk),
        .we    (state_reg == S_WR),
        .waddr (addr_reg),
        .wdata (sum),
        .re    (state_reg == S_RD),
        .raddr ({ty[0], tx}),
        .rdata (rdata)
    );

    genvar c;
    generate
        for (c = 0; c < NCH; c++)
        begin : g_lane
            assign sum[c] = first_reg ? term_reg[c] : rdata[c] + term_reg[c];

            always_ff @(posedge clk)
            begin
                if (state_reg == S_MUL)
                    term_reg[c] <= {24'b0, chan_val[c]} * {16'b0, wprod_reg};
                if (state_reg == S_WR && last_reg)
                    sum_reg[c] <= sum[c];
            end

            awmd_div u_div (
                .clk   (clk),
                .rst_n (rst_n),
                .start (state_reg == S_DSTART),
                .sum   (sum_reg[c]),
                .den   (area_reg),
                .done  (div_done[c]),
                .quot  (quot[c])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        area_reg <= {12'b0, pw_c} * {12'b0, ph_c};
        if (in_accept)
        begin
            val_reg <= in_data;
            xi_reg  <= xi;
            yi_reg  <= yi;
        end
        if (state_reg == S_RD)
        begin
            addr_reg  <= {ty[0], tx};
            first_reg <= first_u;
            last_reg  <= last_u;
            wprod_reg <= {12'b0, wx} * {12'b0, wy};
            if (last_u)
                level_reg <= level_u;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        upd_next       = upd_reg;
        have_last_next = have_last_reg;
        pw_next        = pw_reg;
        ph_next        = ph_reg;
        out_load       = 1'b0;
        upd_last       = upd_reg == 2'd3;

        if (cfg_write)
        begin
            case (cfg_index)
                REG_PREV_WIDTH:  pw_next = cfg_data;
                REG_PREV_HEIGHT: ph_next = cfg_data;
                default:         pw_next = pw_reg;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next     = S_RD;
                    upd_next       = 2'd0;
                    have_last_next = 1'b0;
                end
            end
            S_RD:
            begin
                if (upd_ok)
                begin
                    state_next = S_MUL;
                    if (last_u)
                        have_last_next = 1'b1;
                end
                else if (upd_last)
                    state_next = have_last_reg ? S_DSTART : S_IDLE;
                else
                    upd_next = upd_reg + 2'd1;
            end
            S_MUL:
                state_next = S_WR;
            S_WR:
            begin
                if (upd_last)
                    state_next = have_last_reg ? S_DSTART : S_IDLE;
                else
                begin
                    state_next = S_RD;
                    upd_next   = upd_reg + 2'd1;
                end
            end
            S_DSTART:
                state_next = S_DIV;
            S_DIV:
            begin
                if (div_done[0])
                    state_next = S_PUT;
            end
            S_PUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {quot[3], quot[2], quot[1], quot[0], level_reg};
        end
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            upd_reg       <= '0;
            have_last_reg <= 1'b0;
            pw_reg        <= SIZE_W'(1);
            ph_reg        <= SIZE_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            upd_reg       <= upd_next;
            have_last_reg <= have_last_next;
            pw_reg        <= pw_next;
            ph_reg        <= ph_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `AWMD_ASSERT_NOW(a_div_lanes_agree, div_done[0], div_done == {NCH{1'b1}})
    `AWMD_ASSERT_NOW(a_weights_nonzero, in_accept, xi.w0 != '0 && yi.w0 != '0)
    `AWMD_ASSERT_NEXT(a_last_goes_to_div, state_reg == S_WR && last_reg, state_reg != S_IDLE)
endmodule
`default_nettype wire
